### sv/cfp_pkg.sv
`timescale 1ns / 1ps
package cfp_pkg;

  // largest number of data bytes in one frame
  localparam int MAX_DATA = 16;
  localparam int LEN_W    = $clog2(MAX_DATA + 1);

  localparam logic [7:0] START_RESET = 8'd170;

  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_D     = 8'h44;  // 'D'
  localparam logic [7:0] CH_R     = 8'h52;  // 'R'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_RESET  = 2'd1;
  localparam logic [1:0] KIND_NOTICE = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic       load_len;   // latch length byte, seed sum
    logic       add_cmd;    // add command byte, clear position
    logic       add_data;   // add data byte, step position
    logic       load_emit;  // arm frame result counter
    logic       emit_step;  // one frame result pushed
    logic       push;       // load output register
    logic [1:0] push_kind;
  } cfp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_start;
    logic is_pct;
    logic is_zero;
    logic is_space;
    logic is_d_or_r;
    logic len_ok;
    logic len_zero;
    logic data_last;
    logic sum_match;
    logic emit_last;
    logic out_free;
  } cfp_sts_t;

endpackage

### sv/cfp_ctrl.sv
`timescale 1ns / 1ps
module cfp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfp_pkg::cfp_sts_t sts,
  output cfp_pkg::cfp_cmd_t cmd
);
  import cfp_pkg::*;

  localparam logic [3:0] S_HUNT     = 4'd0;
  localparam logic [3:0] S_LENGTH   = 4'd1;
  localparam logic [3:0] S_COMMAND  = 4'd2;
  localparam logic [3:0] S_DATA     = 4'd3;
  localparam logic [3:0] S_SUM      = 4'd4;
  localparam logic [3:0] S_MSG_KIND = 4'd5;
  localparam logic [3:0] S_MSG_NOTE = 4'd6;
  localparam logic [3:0] S_MSG_END  = 4'd7;
  localparam logic [3:0] S_BOOT     = 4'd8;
  localparam logic [3:0] S_EMIT     = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       acc;

  assign in_ready = (state != S_EMIT) && sts.out_free;
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_HUNT: begin
        if (acc) begin
          if (sts.is_start) state_next = S_LENGTH;
          else if (sts.is_pct) state_next = S_MSG_KIND;
          else if (sts.is_zero) state_next = S_BOOT;
        end
      end
      S_LENGTH: begin
        if (acc) begin
          if (sts.len_ok) begin
            cmd.load_len = 1'b1;
            state_next   = S_COMMAND;
          end else begin
            state_next = S_HUNT;
          end
        end
      end
      S_COMMAND: begin
        if (acc) begin
          cmd.add_cmd = 1'b1;
          state_next  = sts.len_zero ? S_SUM : S_DATA;
        end
      end
      S_DATA: begin
        if (acc) begin
          cmd.add_data = 1'b1;
          if (sts.data_last) state_next = S_SUM;
        end
      end
      S_SUM: begin
        if (acc) begin
          if (sts.sum_match) begin
            cmd.load_emit = 1'b1;
            state_next    = S_EMIT;
          end else begin
            state_next = S_HUNT;
          end
        end
      end
      S_MSG_KIND: begin
        if (acc) state_next = sts.is_d_or_r ? S_MSG_NOTE : S_MSG_END;
      end
      S_MSG_NOTE: begin
        if (acc && sts.is_pct) begin
          cmd.push      = 1'b1;
          cmd.push_kind = KIND_NOTICE;
          state_next    = S_HUNT;
        end
      end
      S_MSG_END: begin
        if (acc && sts.is_pct) state_next = S_HUNT;
      end
      S_BOOT: begin
        if (acc) begin
          if (sts.is_space) begin
            cmd.push      = 1'b1;
            cmd.push_kind = KIND_RESET;
          end
          state_next = S_HUNT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_kind = KIND_DATA;
          cmd.emit_step = 1'b1;
          if (sts.emit_last) state_next = S_HUNT;
        end
      end
      default: state_next = S_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/cfp_dp.sv
`timescale 1ns / 1ps
module cfp_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_data,
  output logic [7:0]        start_byte,
  input  cfp_pkg::cfp_cmd_t cmd,
  output cfp_pkg::cfp_sts_t sts,
  output logic              out_valid,
  output logic [1:0]        out_kind,
  input  logic              out_ready
);
  import cfp_pkg::*;

  logic [7:0]     running_sum;
  logic [LEN_W-1:0] payload_length;
  logic [LEN_W-1:0] read_position;
  logic [LEN_W-1:0] emit_count;
  logic [LEN_W:0]   pos_inc;

  assign pos_inc = {1'b0, read_position} + {{LEN_W{1'b0}}, 1'b1};

  always_comb begin
    sts.is_start  = (rx_byte == start_byte);
    sts.is_pct    = (rx_byte == CH_PCT);
    sts.is_zero   = (rx_byte == CH_ZERO);
    sts.is_space  = (rx_byte == CH_SPACE);
    sts.is_d_or_r = (rx_byte inside {CH_D, CH_R});
    sts.len_ok    = (rx_byte != 8'd0) && (rx_byte <= 8'(MAX_DATA + 1));
    sts.len_zero  = (payload_length == '0);
    sts.data_last = (pos_inc >= {1'b0, payload_length});
    sts.sum_match = (rx_byte == running_sum);
    sts.emit_last = (emit_count == LEN_W'(1));
    sts.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte     <= START_RESET;
      running_sum    <= '0;
      payload_length <= '0;
      read_position  <= '0;
      emit_count     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) start_byte <= cfg_data;
      if (cmd.load_len) begin
        running_sum    <= rx_byte;
        payload_length <= LEN_W'(rx_byte - 8'd1);
      end
      if (cmd.add_cmd) begin
        running_sum   <= running_sum + rx_byte;
        read_position <= '0;
      end
      if (cmd.add_data) begin
        running_sum   <= running_sum + rx_byte;
        read_position <= pos_inc[LEN_W-1:0];
      end
      // an empty frame still gives one result
      if (cmd.load_emit) begin
        emit_count <= (payload_length == '0) ? LEN_W'(1) : payload_length;
      end else if (cmd.emit_step) begin
        emit_count <= emit_count - LEN_W'(1);
      end
      if (cmd.push) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) out_kind <= cmd.push_kind;
  end

endmodule

### sv/checksummed_command_frame_parser.sv
`timescale 1ns / 1ps
// Byte-stream parser for checksummed command frames. Each item on the slave
// side is one received byte. A frame is: start byte (APB register 0, reset
// 0xAA), length L in 1..MAX_DATA+1, command byte, L-1 data bytes, then a sum
// byte equal to the 8-bit wrapping sum of length, command and data. A good
// frame yields max(L-1,1) items of kind 0 on the master side; a bad sum is
// dropped quietly. "%D..%" or "%R..%" gives one kind-2 item, any other "%..%"
// gives nothing; "0" then " " gives a kind-1 item. Rate: one byte per cycle
// through the parse state machine while the output is free; after a
// good sum byte the input stalls while items are emitted (more if the master
// side backpressures); the single output register is fed by the emit state.
module checksummed_command_frame_parser (
  input  logic       clk,
  input  logic       rst,
  // slave side
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] rx_byte
  // master side
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [1:0] result_kind, [7:2] zero
  // APB configuration
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic       pready
);
  import cfp_pkg::*;

  cfp_cmd_t   cmd;
  cfp_sts_t   sts;
  logic       cfg_we;
  logic [7:0] start_byte;
  logic [1:0] out_kind;

  // only register 0 exists, aliased at addresses 0-3; addresses 4-7 are ignored
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, start_byte} : 32'd0;

  assign m_tdata = {6'd0, out_kind};

  cfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cfp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (s_tdata),
    .cfg_we     (cfg_we),
    .cfg_data   (pwdata[7:0]),
    .start_byte (start_byte),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (m_tvalid),
    .out_kind   (out_kind),
    .out_ready  (m_tready)
  );

endmodule

### sv/cfp_checker.sv
`timescale 1ns / 1ps
module cfp_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       pready
);
  import cfp_pkg::*;

  // nothing pending out of reset
  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == KIND_DATA || m_tdata[1:0] == KIND_RESET ||
                  m_tdata[1:0] == KIND_NOTICE) && (m_tdata[7:2] == 6'd0))
    else $error("illegal result item");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output item changed");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while output stalled");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind checksummed_command_frame_parser cfp_checker u_cfp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .pready   (pready)
);
